@@ hdl/pss_pkg.sv @@
package pss_pkg;

  // Fixed widths of the configuration and of the internal arithmetic.
  localparam int R_W        = 13;  // disc radius, Q5.8
  localparam int R2_W       = 26;  // radius squared
  localparam int QUO_W      = 33;  // (num << 32) / r2, at most 2^32
  localparam int NQ_W       = 17;  // |d| << 24 / r, at most 2^16
  localparam int NZ_W       = 17;  // integer root of the quotient, at most 2^16
  localparam int DV_STEPS   = 33;  // one quotient bit per stage
  localparam int NX_STEPS   = 17;
  localparam int SQ_STEPS   = 17;  // one root bit per stage
  localparam int SQ_V_W     = 34;
  localparam int SQ_REM_W   = 19;

  // Register map, word index into the APB space.
  localparam logic [2:0] REG_DISC_RADIUS = 3'd0;
  localparam logic [2:0] REG_LIGHT_COS   = 3'd1;
  localparam logic [2:0] REG_LIGHT_SIN   = 3'd2;
  localparam logic [2:0] REG_PHASE_LEVEL = 3'd3;
  localparam logic [2:0] REG_BASE_RED    = 3'd4;
  localparam logic [2:0] REG_BASE_GREEN  = 3'd5;
  localparam logic [2:0] REG_BASE_BLUE   = 3'd6;

  // Shading constants in Q.30 and Q0.16.
  localparam logic signed [35:0] Q30_BAND   = 36'sd53687091;
  localparam logic signed [35:0] Q30_TENTH  = 36'sd107374182;
  localparam logic [31:0]        Q30_DARK   = 32'd21474836;
  localparam logic signed [31:0] Q30_ONE    = 32'sd1073741824;
  localparam logic [16:0]        LIMB_BASE  = 17'd39322;

  // Reciprocals of five: x / 5 == (x * RECIP5_K20) >> 20 for x < 2^18,
  // and (x * RECIP5_K24) >> 24 for x < 2^22.
  localparam logic [17:0] RECIP5_K20 = 18'd209716;
  localparam logic [21:0] RECIP5_K24 = 22'd3355444;

  typedef struct packed {
    logic              cov;
    logic [R2_W-1:0]   qrem;
    logic              qlsb;
    logic [QUO_W-1:0]  qquo;
    logic [R_W-1:0]    xrem;
    logic [NQ_W-1:0]   xquo;
    logic              xneg;
    logic [R_W-1:0]    yrem;
    logic [NQ_W-1:0]   yquo;
    logic              yneg;
  } div_stage_t;

  typedef struct packed {
    logic                 cov;
    logic [SQ_V_W-1:0]    v;
    logic [SQ_REM_W-1:0]  rem;
    logic [NZ_W-1:0]      root;
    logic signed [17:0]   nx;
    logic signed [17:0]   ny;
  } root_stage_t;

  // Scales the shade product by one colour byte and saturates at 255.
  function automatic logic [7:0] chan_sat(input logic [7:0] base, input logic [48:0] prod);
    logic [56:0] p;
    p = base * prod;
    if (p[56:46] > 11'd255) begin
      return 8'd255;
    end
    return p[53:46];
  endfunction

endpackage

@@ hdl/phased_sphere_pixel_shader.sv @@
// Throughput: one pixel word per cycle; the pipeline holds as a whole while the output
// word waits, and the input is taken whenever the output register is empty or drained.
// The depth is set by the bit-per-stage divider (33 stages) and integer root (17 stages).
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the register defaults.
module phased_sphere_pixel_shader #(
  parameter int FRAME_SIZE = 64,
  parameter int CENTER     = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [$clog2(FRAME_SIZE)-1:0] pixel_x_i,
  input  logic [$clog2(FRAME_SIZE)-1:0] pixel_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          covered_o,
  output logic [7:0]                    red_out_o,
  output logic [7:0]                    green_out_o,
  output logic [7:0]                    blue_out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int PIX_W = $clog2(FRAME_SIZE);
  localparam int D_W   = PIX_W + 1;
  localparam int D2_W  = 2 * PIX_W + 1;
  localparam int SH_W  = D2_W + 16;

  // ---------------------------------------------------------------------------
  // Configuration registers. Radius squared and the terminator level are kept
  // alongside, worked out at the write, so that the pipeline only reads them.
  // ---------------------------------------------------------------------------
  logic [pss_pkg::R_W-1:0]  cfg_radius_q;
  logic signed [15:0]       cfg_cos_q;
  logic signed [15:0]       cfg_sin_q;
  logic [15:0]              cfg_phase_q;
  logic [7:0]               cfg_red_q;
  logic [7:0]               cfg_green_q;
  logic [7:0]               cfg_blue_q;
  logic [pss_pkg::R2_W-1:0] r2_q;
  logic signed [31:0]       term_q;
  logic                     wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_radius_q <= 13'd2048;
      cfg_cos_q    <= 16'sd16384;
      cfg_sin_q    <= 16'sd0;
      cfg_phase_q  <= 16'd0;
      cfg_red_q    <= 8'd255;
      cfg_green_q  <= 8'd255;
      cfg_blue_q   <= 8'd255;
      r2_q         <= 26'd4194304;
      term_q       <= pss_pkg::Q30_ONE;
    end else if (wr_en) begin
      case (paddr[4:2])
        pss_pkg::REG_DISC_RADIUS: begin
          cfg_radius_q <= pwdata[12:0];
          r2_q         <= pwdata[12:0] * pwdata[12:0];
        end
        pss_pkg::REG_LIGHT_COS: cfg_cos_q <= pwdata[15:0];
        pss_pkg::REG_LIGHT_SIN: cfg_sin_q <= pwdata[15:0];
        pss_pkg::REG_PHASE_LEVEL: begin
          cfg_phase_q <= pwdata[15:0];
          term_q      <= pss_pkg::Q30_ONE - $signed({1'b0, pwdata[15:0], 15'b0});
        end
        pss_pkg::REG_BASE_RED:   cfg_red_q   <= pwdata[7:0];
        pss_pkg::REG_BASE_GREEN: cfg_green_q <= pwdata[7:0];
        pss_pkg::REG_BASE_BLUE:  cfg_blue_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      pss_pkg::REG_DISC_RADIUS: prdata = {19'b0, cfg_radius_q};
      pss_pkg::REG_LIGHT_COS:   prdata = {16'b0, cfg_cos_q};
      pss_pkg::REG_LIGHT_SIN:   prdata = {16'b0, cfg_sin_q};
      pss_pkg::REG_PHASE_LEVEL: prdata = {16'b0, cfg_phase_q};
      pss_pkg::REG_BASE_RED:    prdata = {24'b0, cfg_red_q};
      pss_pkg::REG_BASE_GREEN:  prdata = {24'b0, cfg_green_q};
      pss_pkg::REG_BASE_BLUE:   prdata = {24'b0, cfg_blue_q};
      default:                  prdata = 32'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance. Every stage moves together; the whole pipe holds while a
  // finished word sits in the output register and is not taken.
  // ---------------------------------------------------------------------------
  logic adv;
  logic out_valid_q;

  assign adv        = out_ready_i || !out_valid_q;
  assign in_ready_o = adv;

  // Stage A: capture the pixel.
  logic             a_vld_q;
  logic [PIX_W-1:0] a_px_q;
  logic [PIX_W-1:0] a_py_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_px_q <= pixel_x_i;
      a_py_q <= pixel_y_i;
    end
  end

  // Stage B: offsets from the centre and their squared distance.
  logic                   b_vld_q;
  logic signed [D_W-1:0]  b_dx_q;
  logic signed [D_W-1:0]  b_dy_q;
  logic [D2_W-1:0]        b_d2_q;
  logic                   b_inr_q;
  logic signed [D_W-1:0]  b_dx_d;
  logic signed [D_W-1:0]  b_dy_d;
  logic signed [2*D_W-1:0] sqx;
  logic signed [2*D_W-1:0] sqy;

  always_comb begin
    b_dx_d = $signed({1'b0, a_px_q}) - $signed(D_W'(CENTER));
    b_dy_d = $signed({1'b0, a_py_q}) - $signed(D_W'(CENTER));
    sqx    = b_dx_d * b_dx_d;
    sqy    = b_dy_d * b_dy_d;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_dx_q  <= b_dx_d;
      b_dy_q  <= b_dy_d;
      b_d2_q  <= D2_W'(sqx) + D2_W'(sqy);
      b_inr_q <= ({1'b0, a_px_q} < (PIX_W + 1)'(FRAME_SIZE)) &&
                 ({1'b0, a_py_q} < (PIX_W + 1)'(FRAME_SIZE));
    end
  end

  // Stage C: coverage test and the starting remainders of the three dividers.
  // The quotient (num << 32) / r2 starts from num >> 1, which is below r2 on
  // a covered pixel; |d| << 24 / r starts from |d| << 7, likewise below r.
  pss_pkg::div_stage_t dv_q   [pss_pkg::DV_STEPS+1];
  logic [pss_pkg::DV_STEPS:0] dv_vld_q;
  pss_pkg::div_stage_t dv0_d;
  logic [SH_W-1:0]     dsh;
  logic [pss_pkg::R2_W-1:0] num;
  logic [PIX_W-1:0]    mag_x;
  logic [PIX_W-1:0]    mag_y;
  logic signed [D_W-1:0] neg_dx;
  logic signed [D_W-1:0] neg_dy;

  always_comb begin
    dsh    = {b_d2_q, 16'b0};
    num    = r2_q - pss_pkg::R2_W'(dsh);
    neg_dx = -b_dx_q;
    neg_dy = -b_dy_q;
    mag_x  = b_dx_q[D_W-1] ? neg_dx[PIX_W-1:0] : b_dx_q[PIX_W-1:0];
    mag_y  = b_dy_q[D_W-1] ? neg_dy[PIX_W-1:0] : b_dy_q[PIX_W-1:0];
    dv0_d.cov  = b_inr_q && (cfg_radius_q != '0) && (dsh <= SH_W'(r2_q));
    dv0_d.qrem = {1'b0, num[pss_pkg::R2_W-1:1]};
    dv0_d.qlsb = num[0];
    dv0_d.qquo = '0;
    dv0_d.xrem = pss_pkg::R_W'({mag_x, 7'b0});
    dv0_d.xquo = '0;
    dv0_d.xneg = b_dx_q[D_W-1];
    dv0_d.yrem = pss_pkg::R_W'({mag_y, 7'b0});
    dv0_d.yquo = '0;
    dv0_d.yneg = b_dy_q[D_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0] <= dv0_d;
    end
  end

  // Restoring dividers, one quotient bit per stage. The coordinate dividers
  // finish after seventeen stages and their results ride along afterwards.
  for (genvar i = 0; i < pss_pkg::DV_STEPS; i++) begin : g_div
    pss_pkg::div_stage_t nxt;
    always_comb begin
      logic [pss_pkg::R2_W:0] qsh;
      logic [pss_pkg::R_W:0]  xsh;
      logic [pss_pkg::R_W:0]  ysh;
      nxt = dv_q[i];
      qsh = {dv_q[i].qrem, (i == 0) ? dv_q[i].qlsb : 1'b0};
      if (qsh >= {1'b0, r2_q}) begin
        nxt.qrem = pss_pkg::R2_W'(qsh - {1'b0, r2_q});
        nxt.qquo = {dv_q[i].qquo[pss_pkg::QUO_W-2:0], 1'b1};
      end else begin
        nxt.qrem = qsh[pss_pkg::R2_W-1:0];
        nxt.qquo = {dv_q[i].qquo[pss_pkg::QUO_W-2:0], 1'b0};
      end
      xsh = {dv_q[i].xrem, 1'b0};
      ysh = {dv_q[i].yrem, 1'b0};
      if (i < pss_pkg::NX_STEPS) begin
        if (xsh >= {1'b0, cfg_radius_q}) begin
          nxt.xrem = pss_pkg::R_W'(xsh - {1'b0, cfg_radius_q});
          nxt.xquo = {dv_q[i].xquo[pss_pkg::NQ_W-2:0], 1'b1};
        end else begin
          nxt.xrem = xsh[pss_pkg::R_W-1:0];
          nxt.xquo = {dv_q[i].xquo[pss_pkg::NQ_W-2:0], 1'b0};
        end
        if (ysh >= {1'b0, cfg_radius_q}) begin
          nxt.yrem = pss_pkg::R_W'(ysh - {1'b0, cfg_radius_q});
          nxt.yquo = {dv_q[i].yquo[pss_pkg::NQ_W-2:0], 1'b1};
        end else begin
          nxt.yrem = ysh[pss_pkg::R_W-1:0];
          nxt.yquo = {dv_q[i].yquo[pss_pkg::NQ_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[i+1] <= nxt;
      end
    end
  end

  // Integer root of the quotient, two radicand bits and one root bit per
  // stage. The first stage also signs the normal's x and y components.
  pss_pkg::root_stage_t sq_q [pss_pkg::SQ_STEPS+1];
  logic [pss_pkg::SQ_STEPS:0] sq_vld_q;
  pss_pkg::root_stage_t sq0_d;

  always_comb begin
    sq0_d.cov  = dv_q[pss_pkg::DV_STEPS].cov;
    sq0_d.v    = {1'b0, dv_q[pss_pkg::DV_STEPS].qquo};
    sq0_d.rem  = '0;
    sq0_d.root = '0;
    sq0_d.nx   = dv_q[pss_pkg::DV_STEPS].xneg ?
                 -$signed({1'b0, dv_q[pss_pkg::DV_STEPS].xquo}) :
                  $signed({1'b0, dv_q[pss_pkg::DV_STEPS].xquo});
    sq0_d.ny   = dv_q[pss_pkg::DV_STEPS].yneg ?
                 -$signed({1'b0, dv_q[pss_pkg::DV_STEPS].yquo}) :
                  $signed({1'b0, dv_q[pss_pkg::DV_STEPS].yquo});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0] <= sq0_d;
    end
  end

  for (genvar i = 0; i < pss_pkg::SQ_STEPS; i++) begin : g_root
    pss_pkg::root_stage_t nxt;
    always_comb begin
      logic [pss_pkg::SQ_REM_W+1:0] rs;
      logic [pss_pkg::SQ_REM_W-1:0] trial;
      nxt   = sq_q[i];
      rs    = {sq_q[i].rem, sq_q[i].v[pss_pkg::SQ_V_W-1:pss_pkg::SQ_V_W-2]};
      trial = {sq_q[i].root, 2'b01};
      nxt.v = {sq_q[i].v[pss_pkg::SQ_V_W-3:0], 2'b00};
      if (rs >= (pss_pkg::SQ_REM_W + 2)'(trial)) begin
        nxt.rem  = pss_pkg::SQ_REM_W'(rs - (pss_pkg::SQ_REM_W + 2)'(trial));
        nxt.root = {sq_q[i].root[pss_pkg::NZ_W-2:0], 1'b1};
      end else begin
        nxt.rem  = rs[pss_pkg::SQ_REM_W-1:0];
        nxt.root = {sq_q[i].root[pss_pkg::NZ_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[i+1] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shading stages E1 to E9.
  // E1: illumination products and the scaled limb term.
  // E2: illumination sum and limb factor.
  // E3: offset from the terminator, magnitude of twice the illumination.
  // E4..E7: 0.4 * illumination, divided by five in two seventeen-bit digits.
  // E8: shade value for the lit face, the terminator band or the dark face.
  // E9: shade times limb factor. The output stage scales by the colour bytes.
  // ---------------------------------------------------------------------------
  logic [9:1] e_vld_q;

  logic                        e1_cov_q;
  logic [pss_pkg::NZ_W-1:0]    e1_nz_q;
  logic signed [33:0]          e1_pc_q;
  logic signed [33:0]          e1_ps_q;
  logic [39:0]                 e1_lm_q;

  logic                        e2_cov_q;
  logic [pss_pkg::NZ_W-1:0]    e2_nz_q;
  logic signed [34:0]          e2_illum_q;
  logic [16:0]                 e2_limb_q;

  logic                        e3_cov_q;
  logic [pss_pkg::NZ_W-1:0]    e3_nz_q;
  logic [16:0]                 e3_limb_q;
  logic signed [35:0]          e3_vis_q;
  logic [33:0]                 e3_amag_q;
  logic                        e3_aneg_q;
  logic signed [34:0]          e3_abs_d;

  logic                        e4_cov_q;
  logic [pss_pkg::NZ_W-1:0]    e4_nz_q;
  logic [16:0]                 e4_limb_q;
  logic signed [35:0]          e4_vis_q;
  logic                        e4_aneg_q;
  logic [16:0]                 e4_hi_q;
  logic [16:0]                 e4_lo_q;
  logic [34:0]                 e4_qhp_q;

  logic                        e5_cov_q;
  logic [pss_pkg::NZ_W-1:0]    e5_nz_q;
  logic [16:0]                 e5_limb_q;
  logic signed [35:0]          e5_vis_q;
  logic                        e5_aneg_q;
  logic [14:0]                 e5_qh_q;
  logic [2:0]                  e5_rh_q;
  logic [16:0]                 e5_lo_q;
  logic [17:0]                 e5_qh5_d;

  logic                        e6_cov_q;
  logic [pss_pkg::NZ_W-1:0]    e6_nz_q;
  logic [16:0]                 e6_limb_q;
  logic signed [35:0]          e6_vis_q;
  logic                        e6_aneg_q;
  logic [14:0]                 e6_qh_q;
  logic [41:0]                 e6_tq_q;

  logic                        e7_cov_q;
  logic [pss_pkg::NZ_W-1:0]    e7_nz_q;
  logic [16:0]                 e7_limb_q;
  logic signed [35:0]          e7_vis_q;
  logic signed [32:0]          e7_a_q;
  logic [31:0]                 e7_q_d;

  logic                        e8_cov_q;
  logic [16:0]                 e8_limb_q;
  logic [31:0]                 e8_f_q;
  logic [31:0]                 e8_f_d;
  logic signed [35:0]          flit;
  logic signed [35:0]          fband;

  logic                        e9_cov_q;
  logic [48:0]                 e9_prod_q;

  always_comb begin
    e3_abs_d = e2_illum_q[34] ? -e2_illum_q : e2_illum_q;
    e5_qh5_d = {1'b0, e4_qhp_q[34:20], 2'b00} + {3'b0, e4_qhp_q[34:20]};
    e7_q_d   = {e6_qh_q, 17'b0} + 32'(e6_tq_q[41:24]);
    flit     = 36'($signed({1'b0, e7_nz_q, 13'b0})) + 36'(e7_a_q) + pss_pkg::Q30_TENTH;
    fband    = (e7_vis_q + pss_pkg::Q30_BAND) * 36'sd3;
    if (e7_vis_q > pss_pkg::Q30_BAND) begin
      e8_f_d = flit[35] ? 32'd0 : flit[31:0];
    end else if (e7_vis_q > -pss_pkg::Q30_BAND) begin
      e8_f_d = fband[35] ? 32'd0 : fband[31:0];
    end else begin
      e8_f_d = pss_pkg::Q30_DARK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_cov_q   <= sq_q[pss_pkg::SQ_STEPS].cov;
      e1_nz_q    <= sq_q[pss_pkg::SQ_STEPS].root;
      e1_pc_q    <= sq_q[pss_pkg::SQ_STEPS].nx * cfg_cos_q;
      e1_ps_q    <= sq_q[pss_pkg::SQ_STEPS].ny * cfg_sin_q;
      e1_lm_q    <= {sq_q[pss_pkg::SQ_STEPS].root, 1'b0} * pss_pkg::RECIP5_K24;

      e2_cov_q   <= e1_cov_q;
      e2_nz_q    <= e1_nz_q;
      e2_illum_q <= 35'(e1_pc_q) + 35'(e1_ps_q);
      e2_limb_q  <= pss_pkg::LIMB_BASE + 17'(e1_lm_q[39:24]);

      e3_cov_q   <= e2_cov_q;
      e3_nz_q    <= e2_nz_q;
      e3_limb_q  <= e2_limb_q;
      e3_vis_q   <= 36'(e2_illum_q) - 36'(term_q);
      e3_amag_q  <= {e3_abs_d[32:0], 1'b0};
      e3_aneg_q  <= e2_illum_q[34];

      e4_cov_q   <= e3_cov_q;
      e4_nz_q    <= e3_nz_q;
      e4_limb_q  <= e3_limb_q;
      e4_vis_q   <= e3_vis_q;
      e4_aneg_q  <= e3_aneg_q;
      e4_hi_q    <= e3_amag_q[33:17];
      e4_lo_q    <= e3_amag_q[16:0];
      e4_qhp_q   <= e3_amag_q[33:17] * pss_pkg::RECIP5_K20;

      e5_cov_q   <= e4_cov_q;
      e5_nz_q    <= e4_nz_q;
      e5_limb_q  <= e4_limb_q;
      e5_vis_q   <= e4_vis_q;
      e5_aneg_q  <= e4_aneg_q;
      e5_qh_q    <= e4_qhp_q[34:20];
      e5_rh_q    <= 3'({1'b0, e4_hi_q} - e5_qh5_d);
      e5_lo_q    <= e4_lo_q;

      e6_cov_q   <= e5_cov_q;
      e6_nz_q    <= e5_nz_q;
      e6_limb_q  <= e5_limb_q;
      e6_vis_q   <= e5_vis_q;
      e6_aneg_q  <= e5_aneg_q;
      e6_qh_q    <= e5_qh_q;
      e6_tq_q    <= {e5_rh_q, e5_lo_q} * pss_pkg::RECIP5_K24;

      e7_cov_q   <= e6_cov_q;
      e7_nz_q    <= e6_nz_q;
      e7_limb_q  <= e6_limb_q;
      e7_vis_q   <= e6_vis_q;
      e7_a_q     <= e6_aneg_q ? -$signed({1'b0, e7_q_d}) : $signed({1'b0, e7_q_d});

      e8_cov_q   <= e7_cov_q;
      e8_limb_q  <= e7_limb_q;
      e8_f_q     <= e8_f_d;

      e9_cov_q   <= e8_cov_q;
      e9_prod_q  <= e8_f_q * e8_limb_q;
    end
  end

  // Output register: colour channels, zeroed on a pixel outside the disc.
  logic       covered_q;
  logic [7:0] red_q;
  logic [7:0] green_q;
  logic [7:0] blue_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      covered_q <= e9_cov_q;
      red_q     <= e9_cov_q ? pss_pkg::chan_sat(cfg_red_q, e9_prod_q) : 8'd0;
      green_q   <= e9_cov_q ? pss_pkg::chan_sat(cfg_green_q, e9_prod_q) : 8'd0;
      blue_q    <= e9_cov_q ? pss_pkg::chan_sat(cfg_blue_q, e9_prod_q) : 8'd0;
    end
  end

  // Valid bits travel with the words and are the only reset pipeline state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      dv_vld_q    <= '0;
      sq_vld_q    <= '0;
      e_vld_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_vld_q     <= in_valid_i;
      b_vld_q     <= a_vld_q;
      dv_vld_q    <= {dv_vld_q[pss_pkg::DV_STEPS-1:0], b_vld_q};
      sq_vld_q    <= {sq_vld_q[pss_pkg::SQ_STEPS-1:0], dv_vld_q[pss_pkg::DV_STEPS]};
      e_vld_q     <= {e_vld_q[8:1], sq_vld_q[pss_pkg::SQ_STEPS]};
      out_valid_q <= e_vld_q[9];
    end
  end

  assign out_valid_o = out_valid_q;
  assign covered_o   = covered_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;

endmodule

@@ hdl/pss_checker.sv @@
module pss_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       covered_o,
  input logic [7:0] red_out_o,
  input logic [7:0] green_out_o,
  input logic [7:0] blue_out_o,
  input logic       pready
);

  // A held output word keeps its value until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(covered_o) &&
      $stable(red_out_o) && $stable(green_out_o) && $stable(blue_out_o))
    else $error("output word changed while stalled");

  // A pixel outside the disc carries a black colour.
  a_uncovered_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !covered_o |-> red_out_o == 8'd0 && green_out_o == 8'd0 &&
      blue_out_o == 8'd0)
    else $error("uncovered pixel with non-zero colour");

  // Input is only held back by a waiting output word.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with output free");

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind phased_sphere_pixel_shader pss_checker u_pss_checker (.*);
